FILE: src/dmtc_pkg.sv
// Package with the shared types and constants of the door motor travel controller.
package dmtc_pkg;

  // Door positions as reported on the result channel.
  typedef enum logic [2:0] {
    DOOR_CLOSED  = 3'd0,
    DOOR_OPENING = 3'd1,
    DOOR_OPEN    = 3'd2,
    DOOR_CLOSING = 3'd3,
    DOOR_STUCK   = 3'd4
  } door_mode_t;

  // Health codes.
  typedef enum logic [1:0] {
    HEALTH_OK    = 2'd0,
    HEALTH_PINCH = 2'd1,
    HEALTH_STALL = 2'd2
  } health_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    CTL_IDLE = 2'd0,
    CTL_DIV  = 2'd1,
    CTL_DONE = 2'd2
  } ctl_state_t;

  // Command codes carried by an input item.
  localparam logic [2:0] FUNC_NONE  = 3'd0;
  localparam logic [2:0] FUNC_OPEN  = 3'd1;
  localparam logic [2:0] FUNC_CLOSE = 3'd2;
  localparam logic [2:0] FUNC_STOP  = 3'd3;
  localparam logic [2:0] FUNC_STUCK = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SIM_MODE    = 3'd0;
  localparam logic [2:0] CFG_PINCH_MA    = 3'd1;
  localparam logic [2:0] CFG_TIMEOUT_S   = 3'd2;
  localparam logic [2:0] CFG_DRIVE_DUTY  = 3'd3;
  localparam logic [2:0] CFG_SIM_TRAVEL  = 3'd4;

  // Configuration reset values.
  localparam logic [15:0] PINCH_MA_RST   = 16'd2000;
  localparam logic [7:0]  TIMEOUT_S_RST  = 8'd30;
  localparam logic [7:0]  DRIVE_DUTY_RST = 8'd200;
  localparam logic [15:0] SIM_TRAVEL_RST = 16'd2000;

  localparam logic [17:0] TIMER_MAX     = 18'h3FFFF;
  localparam logic [17:0] MS_PER_SECOND = 18'd1000;

  localparam int DIV_BITS = 32;

endpackage

FILE: src/dmtc_if.sv
// Handshake channel interfaces for tick items, result items and configuration writes.
interface dmtc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic        limit_open_n;
  logic        limit_close_n;
  logic [15:0] current_ma;
  logic [9:0]  elapsed_ms;

  modport source (output valid, func, limit_open_n, limit_close_n, current_ma, elapsed_ms,
                  input ready);
  modport sink   (input valid, func, limit_open_n, limit_close_n, current_ma, elapsed_ms,
                  output ready);
endinterface

interface dmtc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  door_state;
  logic [7:0]  duty_open_channel;
  logic [7:0]  duty_close_channel;
  logic [1:0]  health;
  logic [31:0] open_cycles;
  logic [31:0] close_cycles;
  logic [15:0] peak_ma;
  logic [15:0] average_ma;

  modport source (output valid, door_state, duty_open_channel, duty_close_channel, health,
                  open_cycles, close_cycles, peak_ma, average_ma,
                  input ready);
  modport sink   (input valid, door_state, duty_open_channel, duty_close_channel, health,
                  open_cycles, close_cycles, peak_ma, average_ma,
                  output ready);
endinterface

interface dmtc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: src/door_motor_travel_controller.sv
// Top level of the door motor travel controller: tick update, serial averager and result register.
// Flow: a tick item is applied to the door state at the accepting edge, then the average divider
// runs its 32 shift-subtract steps, and the result is loaded once the output register is free.
// A new tick item is taken only after the previous result has been loaded into the output register.
// Reset: synchronous, active low rst_n; clears the door state, counters, telemetry and health,
// returns configuration to its defaults and empties the output register.
module door_motor_travel_controller
  import dmtc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  dmtc_in_if.sink    in_if,
  dmtc_out_if.source out_if,
  dmtc_cfg_if.sink   cfg_if
);

  localparam int CNT_BITS = $clog2(DIV_BITS);

  // Configuration registers. Writes are always taken.
  logic        sim_mode_r;
  logic [15:0] pinch_ma_r;
  logic [7:0]  timeout_s_r;
  logic [7:0]  drive_duty_r;
  logic [15:0] sim_travel_r;

  // Door state and telemetry.
  door_mode_t            mode_r,   mode_nxt;
  health_t               health_r, health_nxt;
  logic [17:0]           timer_r,  timer_nxt;
  logic [COUNT_BITS-1:0] open_cnt_r, open_cnt_nxt;
  logic [COUNT_BITS-1:0] close_cnt_r, close_cnt_nxt;
  logic [15:0]           peak_r,   peak_nxt;
  logic [31:0]           ctot_r,   ctot_nxt;
  logic [31:0]           stot_r,   stot_nxt;

  // Sequencer and divider.
  ctl_state_t          ctl_r, ctl_nxt;
  logic [CNT_BITS-1:0] div_cnt_r;
  logic [31:0]         quo_r;
  logic [31:0]         rem_r;
  logic                in_ready;
  logic                load_out;
  logic                accept;

  // Output register.
  logic        out_valid_r;
  logic [2:0]  out_state_r;
  logic [7:0]  out_duty_open_r;
  logic [7:0]  out_duty_close_r;
  logic [1:0]  out_health_r;
  logic [31:0] out_open_r;
  logic [31:0] out_close_r;
  logic [15:0] out_peak_r;
  logic [15:0] out_avg_r;

  // Tick update helpers.
  logic [18:0]           timer_sum;
  logic [32:0]           cur_sum;
  logic [17:0]           timeout_limit;
  logic [COUNT_BITS-1:0] open_bump;
  logic [COUNT_BITS-1:0] close_bump;
  logic                  moving;

  // Divider step.
  logic [32:0] rem_sh;
  logic [32:0] rem_diff;

  logic [63:0] open_wide;
  logic [63:0] close_wide;

  assign accept = in_if.valid && in_ready;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sim_mode_r   <= 1'b0;
      pinch_ma_r   <= PINCH_MA_RST;
      timeout_s_r  <= TIMEOUT_S_RST;
      drive_duty_r <= DRIVE_DUTY_RST;
      sim_travel_r <= SIM_TRAVEL_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.reg_index)
        CFG_SIM_MODE:   sim_mode_r   <= cfg_if.wdata[0];
        CFG_PINCH_MA:   pinch_ma_r   <= cfg_if.wdata;
        CFG_TIMEOUT_S:  timeout_s_r  <= cfg_if.wdata[7:0];
        CFG_DRIVE_DUTY: drive_duty_r <= cfg_if.wdata[7:0];
        CFG_SIM_TRAVEL: sim_travel_r <= cfg_if.wdata;
        default: ;
      endcase
    end
  end

  // One tick: timer advance, command, then either timed travel or the real-mode checks
  // in order (telemetry, limit stops, pinch trip, timeout trip).
  always_comb begin
    timer_sum     = {1'b0, timer_r} + {9'd0, in_if.elapsed_ms};
    cur_sum       = {1'b0, ctot_r} + {17'd0, in_if.current_ma};
    timeout_limit = {10'd0, timeout_s_r} * MS_PER_SECOND;
    open_bump     = (open_cnt_r == '1) ? open_cnt_r : open_cnt_r + 1'b1;
    close_bump    = (close_cnt_r == '1) ? close_cnt_r : close_cnt_r + 1'b1;

    timer_nxt     = timer_sum[18] ? TIMER_MAX : timer_sum[17:0];
    mode_nxt      = mode_r;
    health_nxt    = health_r;
    open_cnt_nxt  = open_cnt_r;
    close_cnt_nxt = close_cnt_r;
    peak_nxt      = peak_r;
    ctot_nxt      = ctot_r;
    stot_nxt      = stot_r;

    case (in_if.func)
      FUNC_OPEN, FUNC_CLOSE: begin
        mode_nxt   = (in_if.func == FUNC_OPEN) ? DOOR_OPENING : DOOR_CLOSING;
        timer_nxt  = '0;
        health_nxt = HEALTH_OK;
      end
      FUNC_STOP: begin
        if (mode_r == DOOR_OPENING) begin
          mode_nxt     = DOOR_OPEN;
          open_cnt_nxt = open_bump;
        end else if (mode_r == DOOR_CLOSING) begin
          mode_nxt      = DOOR_CLOSED;
          close_cnt_nxt = close_bump;
        end
      end
      FUNC_STUCK: mode_nxt = DOOR_STUCK;
      default: ;
    endcase

    moving = (mode_nxt == DOOR_OPENING) || (mode_nxt == DOOR_CLOSING);

    if (sim_mode_r) begin
      if (moving && (timer_nxt > {2'd0, sim_travel_r})) begin
        if (mode_nxt == DOOR_OPENING) begin
          mode_nxt     = DOOR_OPEN;
          open_cnt_nxt = open_bump;
        end else begin
          mode_nxt      = DOOR_CLOSED;
          close_cnt_nxt = close_bump;
        end
      end
    end else begin
      if (moving) begin
        if (in_if.current_ma > peak_r) begin
          peak_nxt = in_if.current_ma;
        end
        // Both totals freeze once either would leave 32 bits.
        if ((stot_r != '1) && !cur_sum[32]) begin
          ctot_nxt = cur_sum[31:0];
          stot_nxt = stot_r + 1'b1;
        end
      end
      if ((mode_nxt == DOOR_OPENING) && !in_if.limit_open_n) begin
        mode_nxt     = DOOR_OPEN;
        open_cnt_nxt = open_bump;
        health_nxt   = HEALTH_OK;
      end
      if ((mode_nxt == DOOR_CLOSING) && !in_if.limit_close_n) begin
        mode_nxt      = DOOR_CLOSED;
        close_cnt_nxt = close_bump;
        health_nxt    = HEALTH_OK;
      end
      if (((mode_nxt == DOOR_OPENING) || (mode_nxt == DOOR_CLOSING)) &&
          (in_if.current_ma > pinch_ma_r)) begin
        mode_nxt   = DOOR_STUCK;
        health_nxt = HEALTH_PINCH;
      end
      if (((mode_nxt == DOOR_OPENING) || (mode_nxt == DOOR_CLOSING)) &&
          (timer_nxt > timeout_limit)) begin
        mode_nxt   = DOOR_STUCK;
        health_nxt = HEALTH_STALL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= DOOR_CLOSED;
      health_r    <= HEALTH_OK;
      timer_r     <= '0;
      open_cnt_r  <= '0;
      close_cnt_r <= '0;
      peak_r      <= '0;
      ctot_r      <= '0;
      stot_r      <= '0;
    end else if (accept) begin
      mode_r      <= mode_nxt;
      health_r    <= health_nxt;
      timer_r     <= timer_nxt;
      open_cnt_r  <= open_cnt_nxt;
      close_cnt_r <= close_cnt_nxt;
      peak_r      <= peak_nxt;
      ctot_r      <= ctot_nxt;
      stot_r      <= stot_nxt;
    end
  end

  // Sequencer: idle until a tick arrives, then 32 divider steps, then load the result
  // as soon as the output register is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= CTL_IDLE;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_comb begin
    ctl_nxt  = ctl_r;
    in_ready = 1'b0;
    load_out = 1'b0;
    case (ctl_r)
      CTL_IDLE: begin
        in_ready = 1'b1;
        if (in_if.valid) begin
          ctl_nxt = CTL_DIV;
        end
      end
      CTL_DIV: begin
        if (div_cnt_r == CNT_BITS'(DIV_BITS - 1)) begin
          ctl_nxt = CTL_DONE;
        end
      end
      CTL_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          load_out = 1'b1;
          ctl_nxt  = CTL_IDLE;
        end
      end
      default: ctl_nxt = CTL_IDLE;
    endcase
  end

  assign in_if.ready = in_ready;

  // Restoring shift-subtract divider of the new current sum by the new sample count.
  assign rem_sh   = {rem_r, quo_r[31]};
  assign rem_diff = rem_sh - {1'b0, stot_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      quo_r     <= ctot_nxt;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (ctl_r == CTL_DIV) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      if (!rem_diff[32]) begin
        rem_r <= rem_diff[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        quo_r <= {quo_r[30:0], 1'b0};
      end
    end
  end

  assign open_wide  = 64'(open_cnt_r);
  assign close_wide = 64'(close_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_state_r      <= mode_r;
      out_duty_open_r  <= (!sim_mode_r && (mode_r == DOOR_OPENING)) ? drive_duty_r : 8'd0;
      out_duty_close_r <= (!sim_mode_r && (mode_r == DOOR_CLOSING)) ? drive_duty_r : 8'd0;
      out_health_r     <= health_r;
      out_open_r       <= open_wide[31:0];
      out_close_r      <= close_wide[31:0];
      out_peak_r       <= peak_r;
      out_avg_r        <= (stot_r == '0) ? 16'd0 : quo_r[15:0];
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.door_state         = out_state_r;
  assign out_if.duty_open_channel  = out_duty_open_r;
  assign out_if.duty_close_channel = out_duty_close_r;
  assign out_if.health             = out_health_r;
  assign out_if.open_cycles        = out_open_r;
  assign out_if.close_cycles       = out_close_r;
  assign out_if.peak_ma            = out_peak_r;
  assign out_if.average_ma         = out_avg_r;

endmodule

FILE: tb/door_motor_travel_controller_tb.sv
// Self-checking testbench for the door motor travel controller with its own tick predictor.
`timescale 1ns / 100ps

module door_motor_travel_controller_tb;
  import dmtc_pkg::*;

  // Width of the saturating travel counters inside the block.
  localparam int COUNT_BITS = 32;
  localparam logic [63:0] COUNT_MAX = {64{1'b1}} >> (64 - COUNT_BITS);
  // Long enough for a tick to pass through the divider and into the output register.
  localparam int SETTLE_CYCLES = 40;
  // Number of tick items after which the random traffic stops.
  localparam int TICK_TARGET = 1550;

  // One poll tick as it travels on the input channel.
  typedef struct packed {
    logic [2:0]  func;
    logic        lim_open_n;
    logic        lim_close_n;
    logic [15:0] cur;
    logic [9:0]  el;
  } tick_t;

  // One result item as the block should report it.
  typedef struct packed {
    door_mode_t  door;
    logic [7:0]  duty_o;
    logic [7:0]  duty_c;
    health_t     health;
    logic [31:0] opens;
    logic [31:0] closes;
    logic [15:0] peak;
    logic [15:0] avg;
  } door_result_t;

  logic clk;
  logic rst_n;

  dmtc_in_if  in_ch();
  dmtc_out_if out_ch();
  dmtc_cfg_if cfg_ch();

  door_motor_travel_controller #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // The testbench's own copy of the configuration registers.
  logic        sim_mode;
  logic [15:0] pinch_ma;
  logic [7:0]  timeout_s;
  logic [7:0]  duty;
  logic [15:0] sim_travel_ms;

  // The testbench's own copy of the door state and telemetry.
  door_mode_t  door;
  logic [17:0] travel_ms;
  logic [63:0] opens;
  logic [63:0] closes;
  logic [15:0] peak_ma;
  logic [31:0] ma_sum;
  logic [31:0] ma_samples;
  health_t     health;

  // Results still owed by the block, oldest first.
  door_result_t pending_reports[$];

  int errors;
  int ticks_sent;
  // When clear, the sender offers items back to back.
  bit gaps_on;
  // Set by the backpressure test; the receiver then holds ready low for this many cycles.
  int hold_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Puts the predictor into the state the block has right after reset.
  task automatic model_reset();
    sim_mode      = 1'b0;
    pinch_ma      = PINCH_MA_RST;
    timeout_s     = TIMEOUT_S_RST;
    duty          = DRIVE_DUTY_RST;
    sim_travel_ms = SIM_TRAVEL_RST;
    door          = DOOR_CLOSED;
    travel_ms     = '0;
    opens         = '0;
    closes        = '0;
    peak_ma       = '0;
    ma_sum        = '0;
    ma_samples    = '0;
    health        = HEALTH_OK;
  endtask

  function automatic bit is_moving();
    return door == DOOR_OPENING || door == DOOR_CLOSING;
  endfunction

  function automatic logic [63:0] bump(logic [63:0] c);
    return (c < COUNT_MAX) ? c + 64'd1 : c;
  endfunction

  // Applies one tick to the predicted door and returns the result the block must report.
  function automatic door_result_t advance_door(tick_t t);
    logic [18:0]  timer_sum;
    logic [32:0]  sum_next;
    door_result_t r;
    // The travel timer runs on every tick and sticks at its maximum.
    timer_sum = {1'b0, travel_ms} + 19'(t.el);
    travel_ms = (timer_sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : timer_sum[17:0];

    // Commands come first. Open and close restart travel from any state, even stuck.
    case (t.func)
      FUNC_OPEN, FUNC_CLOSE: begin
        door      = (t.func == FUNC_OPEN) ? DOOR_OPENING : DOOR_CLOSING;
        travel_ms = '0;
        health    = HEALTH_OK;
      end
      FUNC_STOP: begin
        // A stop completes a travel in progress and leaves the health code alone.
        if (door == DOOR_OPENING) begin
          door  = DOOR_OPEN;
          opens = bump(opens);
        end else if (door == DOOR_CLOSING) begin
          door   = DOOR_CLOSED;
          closes = bump(closes);
        end
      end
      FUNC_STUCK: door = DOOR_STUCK;
      default: ;
    endcase

    if (sim_mode) begin
      // Simulated travel ends on time alone; switches and current are ignored.
      if (is_moving() && travel_ms > 18'(sim_travel_ms)) begin
        if (door == DOOR_OPENING) begin
          door  = DOOR_OPEN;
          opens = bump(opens);
        end else begin
          door   = DOOR_CLOSED;
          closes = bump(closes);
        end
      end
    end else begin
      // Telemetry is taken while moving. Once the sum or the count would overflow,
      // both stay frozen.
      if (is_moving()) begin
        if (t.cur > peak_ma) peak_ma = t.cur;
        sum_next = {1'b0, ma_sum} + 33'(t.cur);
        if (ma_samples != '1 && !sum_next[32]) begin
          ma_sum     = sum_next[31:0];
          ma_samples = ma_samples + 32'd1;
        end
      end
      // A limit switch of the travel direction ends the travel before any trip check.
      if (door == DOOR_OPENING && !t.lim_open_n) begin
        door   = DOOR_OPEN;
        opens  = bump(opens);
        health = HEALTH_OK;
      end
      if (door == DOOR_CLOSING && !t.lim_close_n) begin
        door   = DOOR_CLOSED;
        closes = bump(closes);
        health = HEALTH_OK;
      end
      // A pinch trip stops the door, so the timeout check that follows cannot fire.
      if (is_moving() && t.cur > pinch_ma) begin
        door   = DOOR_STUCK;
        health = HEALTH_PINCH;
      end
      if (is_moving() && 32'(travel_ms) > 32'(timeout_s) * 32'(MS_PER_SECOND)) begin
        door   = DOOR_STUCK;
        health = HEALTH_STALL;
      end
    end

    r.door   = door;
    r.duty_o = (!sim_mode && door == DOOR_OPENING) ? duty : 8'd0;
    r.duty_c = (!sim_mode && door == DOOR_CLOSING) ? duty : 8'd0;
    r.health = health;
    r.opens  = opens[31:0];
    r.closes = closes[31:0];
    r.peak   = peak_ma;
    r.avg    = (ma_samples == 0) ? 16'd0 : 16'(ma_sum / ma_samples);
    return r;
  endfunction

  // Sender idle time: mostly none or short, now and then a long pause.
  function automatic int pick_sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 8);
    if (r < 96) return $urandom_range(9, 40);
    return $urandom_range(41, 100);
  endfunction

  // Receiver stall length: never zero, mostly short.
  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offers one tick, waits for it to be accepted and records the result it owes.
  // Valid is left high so that a following item can go out back to back.
  task automatic send_tick(tick_t t);
    int gap;
    gap = gaps_on ? pick_sender_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= t.func;
    in_ch.limit_open_n  <= t.lim_open_n;
    in_ch.limit_close_n <= t.lim_close_n;
    in_ch.current_ma    <= t.cur;
    in_ch.elapsed_ms    <= t.el;
    do @(posedge clk); while (!in_ch.ready);
    pending_reports.push_back(advance_door(t));
    ticks_sent++;
  endtask

  task automatic drive_tick(logic [2:0] f, logic lo_n, logic lc_n, logic [15:0] cur,
                            logic [9:0] el);
    send_tick({f, lo_n, lc_n, cur, el});
  endtask

  // Lowers valid and waits until every owed result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Writes all five registers while the block is idle. The unused upper bits of the
  // narrow registers carry random junk, which the block has to drop.
  task automatic configure(bit sim, logic [15:0] pinch, logic [7:0] tmo, logic [7:0] drv,
                           logic [15:0] travel);
    write_reg(CFG_SIM_MODE, {15'($urandom), sim});
    write_reg(CFG_PINCH_MA, pinch);
    write_reg(CFG_TIMEOUT_S, {8'($urandom), tmo});
    write_reg(CFG_DRIVE_DUTY, {8'($urandom), drv});
    write_reg(CFG_SIM_TRAVEL, travel);
    cfg_ch.valid  <= 1'b0;
    sim_mode      = sim;
    pinch_ma      = pinch;
    timeout_s     = tmo;
    duty          = drv;
    sim_travel_ms = travel;
  endtask

  // Builds a tick that keeps the door travelling most of the time: commands start
  // travels when it is at rest, and a moving door mostly just gets samples until a
  // limit switch, a trip or a timeout ends the travel.
  function automatic tick_t gen_tick();
    tick_t t;
    int    r;
    r = $urandom_range(0, 99);
    if (is_moving()) begin
      if (r < 3) t.func = FUNC_STOP;
      else if (r < 5) t.func = FUNC_STUCK;
      else if (r < 9) t.func = $urandom_range(0, 1) ? FUNC_OPEN : FUNC_CLOSE;
      else if (r < 11) t.func = 3'($urandom_range(5, 7));
      else t.func = FUNC_NONE;
    end else begin
      if (r < 45) t.func = $urandom_range(0, 1) ? FUNC_OPEN : FUNC_CLOSE;
      else if (r < 50) t.func = FUNC_STOP;
      else if (r < 53) t.func = FUNC_STUCK;
      else if (r < 56) t.func = 3'($urandom_range(5, 7));
      else t.func = FUNC_NONE;
    end
    t.lim_open_n  = ($urandom_range(0, 9) != 0);
    t.lim_close_n = ($urandom_range(0, 9) != 0);
    // Currents stay mostly at or below the pinch level so travels can finish.
    r = $urandom_range(0, 99);
    if (r < 80) t.cur = 16'($urandom_range(0, pinch_ma));
    else if (r < 85) t.cur = pinch_ma;
    else if (r < 88) t.cur = (pinch_ma == 16'hFFFF) ? pinch_ma : pinch_ma + 16'd1;
    else t.cur = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 60) t.el = 10'($urandom_range(0, 200));
    else if (r < 85) t.el = 10'($urandom_range(0, 1023));
    else if (r < 95) t.el = 10'($urandom_range(900, 1023));
    else t.el = 10'd0;
    return t;
  endfunction

  // Picks a configuration for one random phase; the first phases take the extremes.
  task automatic configure_phase(int phase);
    bit          sim;
    logic [15:0] pinch;
    logic [15:0] travel;
    logic [7:0]  tmo;
    logic [7:0]  drv;
    int          r;
    case (phase)
      0: begin
        sim = 1'b0; pinch = 16'd0; tmo = 8'd0; drv = 8'd0; travel = 16'd0;
      end
      1: begin
        sim = 1'b0; pinch = 16'hFFFF; tmo = 8'hFF; drv = 8'hFF; travel = 16'hFFFF;
      end
      2: begin
        sim = 1'b1; pinch = 16'($urandom); tmo = 8'($urandom); drv = 8'hFF; travel = 16'd0;
      end
      3: begin
        sim = 1'b1; pinch = 16'd0; tmo = 8'd0; drv = 8'd0; travel = 16'hFFFF;
      end
      default: begin
        sim = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 9);
        if (r == 0) pinch = 16'hFFFF;
        else if (r == 1) pinch = 16'd0;
        else if (r < 6) pinch = 16'($urandom_range(500, 4000));
        else pinch = 16'($urandom);
        // Short timeouts make stall trips common.
        r = $urandom_range(0, 9);
        if (r < 6) tmo = 8'($urandom_range(0, 3));
        else if (r < 8) tmo = 8'($urandom_range(4, 40));
        else if (r == 8) tmo = 8'hFF;
        else tmo = 8'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0) drv = 8'd0;
        else if (r == 1) drv = 8'hFF;
        else drv = 8'($urandom);
        r = $urandom_range(0, 9);
        if (r < 6) travel = 16'($urandom_range(0, 3000));
        else if (r < 8) travel = 16'($urandom_range(0, 300));
        else if (r == 8) travel = 16'hFFFF;
        else travel = 16'($urandom);
      end
    endcase
    configure(sim, pinch, tmo, drv, travel);
  endtask

  // Every command and the reserved codes under the reset configuration.
  task automatic test_commands();
    drive_tick(FUNC_NONE, 1'b1, 1'b1, 16'd0, 10'd0);
    // Reserved codes are ignored even with switches low and extreme samples.
    drive_tick(3'd5, 1'b0, 1'b0, 16'hFFFF, 10'd1023);
    drive_tick(3'd6, 1'b1, 1'b0, 16'hFFFF, 10'd1023);
    drive_tick(3'd7, 1'b0, 1'b1, 16'hFFFF, 10'd1023);
    // Stop on a closed door changes nothing.
    drive_tick(FUNC_STOP, 1'b1, 1'b1, 16'd123, 10'd1);
    drive_tick(FUNC_OPEN, 1'b1, 1'b1, 16'd1500, 10'd100);
    // The close switch is noise while opening, and a current equal to the threshold is fine.
    drive_tick(FUNC_NONE, 1'b1, 1'b0, 16'd2000, 10'd1023);
    drive_tick(FUNC_NONE, 1'b0, 1'b1, 16'd700, 10'd10);
    drive_tick(FUNC_STOP, 1'b1, 1'b1, 16'd0, 10'd0);
    // One milliamp above the threshold trips as pinched.
    drive_tick(FUNC_CLOSE, 1'b1, 1'b1, 16'd2001, 10'd5);
    // Open from stuck clears the health code.
    drive_tick(FUNC_OPEN, 1'b1, 1'b1, 16'd0, 10'd0);
    drive_tick(FUNC_STOP, 1'b1, 1'b1, 16'd0, 10'd0);
    drive_tick(FUNC_CLOSE, 1'b1, 1'b1, 16'd100, 10'd50);
    drive_tick(FUNC_STUCK, 1'b1, 1'b1, 16'hFFFF, 10'd1023);
    // The switch closes the travel on the command's own tick, so the pinch is never seen.
    drive_tick(FUNC_CLOSE, 1'b1, 1'b0, 16'hFFFF, 10'd0);
  endtask

  // Timeout at its extremes and the priority between limit, pinch and timeout.
  task automatic test_trip_order();
    wait_drained();
    configure(1'b0, 16'd1000, 8'd0, 8'hFF, SIM_TRAVEL_RST);
    // The timer is cleared by the command, so a zero timeout does not fire at once.
    drive_tick(FUNC_OPEN, 1'b1, 1'b1, 16'd500, 10'd1023);
    drive_tick(FUNC_NONE, 1'b1, 1'b1, 16'd500, 10'd0);
    drive_tick(FUNC_NONE, 1'b1, 1'b1, 16'd500, 10'd1);
    drive_tick(FUNC_CLOSE, 1'b1, 1'b1, 16'd400, 10'd0);
    // Pinch and timeout on the same tick report the pinch.
    drive_tick(FUNC_NONE, 1'b1, 1'b1, 16'd1001, 10'd1);
    drive_tick(FUNC_OPEN, 1'b1, 1'b1, 16'd0, 10'd0);
    drive_tick(FUNC_NONE, 1'b0, 1'b1, 16'd5000, 10'd1023);
    wait_drained();
    // Largest threshold and timeout with zero duty: the largest sample is not a pinch.
    configure(1'b0, 16'hFFFF, 8'hFF, 8'd0, 16'hFFFF);
    drive_tick(FUNC_OPEN, 1'b1, 1'b1, 16'hFFFF, 10'd1023);
    drive_tick(FUNC_NONE, 1'b1, 1'b1, 16'hFFFF, 10'd1023);
  endtask

  // Simulated mode: no drive, no telemetry, travel ends once the timer passes the set time.
  task automatic test_simulated_travel();
    wait_drained();
    configure(1'b1, 16'd0, 8'd0, 8'hFF, 16'd0);
    drive_tick(FUNC_OPEN, 1'b0, 1'b0, 16'hFFFF, 10'd500);
    drive_tick(FUNC_NONE, 1'b0, 1'b0, 16'hFFFF, 10'd1);
    drive_tick(FUNC_CLOSE, 1'b1, 1'b1, 16'd0, 10'd0);
    drive_tick(FUNC_STOP, 1'b1, 1'b1, 16'd0, 10'd0);
  endtask

  // The receiver holds off for a long stretch while items keep coming back to back,
  // so the block fills up and has to stall its input.
  task automatic test_backpressure();
    wait_drained();
    configure_phase(4);
    gaps_on     = 1'b0;
    hold_cycles = 300;
    repeat (12) send_tick(gen_tick());
    gaps_on = 1'b1;
  endtask

  // Random phases, each under its own configuration, until enough ticks have gone in.
  task automatic test_random_traffic();
    int phase;
    int n;
    phase = 0;
    while (ticks_sent < TICK_TARGET) begin
      wait_drained();
      configure_phase(phase);
      // One phase in five runs with no sender gaps at all.
      gaps_on = ($urandom_range(0, 4) != 0);
      n = $urandom_range(40, 120);
      repeat (n) send_tick(gen_tick());
      phase++;
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: random nonzero stalls, ready stretches of varying length,
  // and the long hold-off that the backpressure test asks for.
  initial begin : receiver
    int n;
    forever begin
      out_ch.ready <= 1'b0;
      if (hold_cycles > 0) begin
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        repeat (pick_stall()) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      for (int i = 0; i < n && hold_cycles == 0; i++) @(posedge clk);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Every accepted result is compared with the oldest one still owed.
  always @(posedge clk) begin : result_check
    door_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual door_state %0d", $time,
                 out_ch.door_state);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("door_state", 32'(want.door), 32'(out_ch.door_state));
        check_field("duty_open_channel", 32'(want.duty_o), 32'(out_ch.duty_open_channel));
        check_field("duty_close_channel", 32'(want.duty_c), 32'(out_ch.duty_close_channel));
        check_field("health", 32'(want.health), 32'(out_ch.health));
        check_field("open_cycles", want.opens, out_ch.open_cycles);
        check_field("close_cycles", want.closes, out_ch.close_cycles);
        check_field("peak_ma", 32'(want.peak), 32'(out_ch.peak_ma));
        check_field("average_ma", 32'(want.avg), 32'(out_ch.average_ma));
      end
    end
  end

  // Main sequence: reset once, then the tests in turn, then drain and report.
  initial begin
    errors      = 0;
    ticks_sent  = 0;
    gaps_on     = 1'b1;
    hold_cycles = 0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.func          = FUNC_NONE;
    in_ch.limit_open_n  = 1'b1;
    in_ch.limit_close_n = 1'b1;
    in_ch.current_ma    = '0;
    in_ch.elapsed_ms    = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.reg_index    = CFG_SIM_MODE;
    cfg_ch.wdata        = '0;
    model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_commands();
    test_trip_order();
    test_simulated_travel();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    // Give a stray extra result the time to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: door_motor_travel_controller.f
src/dmtc_pkg.sv
src/dmtc_if.sv
src/door_motor_travel_controller.sv
tb/door_motor_travel_controller_tb.sv
